// ----- rtl/hdlc_bit_deframer_assert.svh -----
// Assertion macros for the HDLC bit deframer.
// Depends on nothing; included by hdlc_bit_deframer, which checks its own logic.
`ifndef HDLC_BIT_DEFRAMER_ASSERT_SVH
`define HDLC_BIT_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HBD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdlc_bit_deframer: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define HBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdlc_bit_deframer: next-cycle check failed");

`endif

// ----- rtl/hbd_pkg.sv -----
// Package for the HDLC bit deframer: register indexes, reset values,
// matching constants and the result type. No dependencies.
package hbd_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FLAG_PATTERN  = 2'd0,
      CSR_ABORT_MASK    = 2'd1,
      CSR_ESCAPE_MARKER = 2'd2
   } csr_index_type;

   // Register reset values
   localparam logic [7:0] FLAG_PATTERN_RST  = 8'h7E;
   localparam logic [7:0] ABORT_MASK_RST    = 8'h7F;
   localparam logic [7:0] ESCAPE_MARKER_RST = 8'h1B;

   // Stuffed-zero detection: low six history bits equal 111110
   localparam logic [7:0] STUFF_MASK  = 8'h3F;
   localparam logic [7:0] STUFF_MATCH = 8'h3E;
   // New data bit enters the assembly at the top
   localparam logic [7:0] ENTRY_BIT   = 8'h80;

   // One output transfer
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } result_type;

endpackage

// ----- rtl/hdlc_bit_deframer.sv -----
// HDLC receive bit deframer: flag/abort detection, zero unstuffing, byte
// assembly and escaping. Depends on hbd_pkg and hdlc_bit_deframer_assert.svh.
// Latency: a result is presented the cycle after its bit is transferred in.
// Throughput: one bit per cycle while rsp_stall is low; a bit that yields an escaped byte (two
// results) holds off the next bit until the escape marker has left the two-entry result queue.
// Reset: synchronous, active high; clears history, frame state, assembly,
// queue and restores the register defaults.
module hdlc_bit_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_rx_bit,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   `include "hdlc_bit_deframer_assert.svh"

   // Configuration registers
   logic [7:0] flag_ff, flag_in;
   logic [7:0] abort_ff, abort_in;
   logic [7:0] escape_ff, escape_in;

   // Deframer state
   logic [7:0] history_ff, history_in;
   logic       in_frame_ff, in_frame_in;
   logic [7:0] asm_ff, asm_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;

   // Result queue: entry 0 is presented
   hbd_pkg::result_type entry0_ff, entry0_in;
   hbd_pkg::result_type entry1_ff, entry1_in;
   logic [1:0]          count_ff, count_in;

   logic                req_xfer;
   logic                rsp_xfer;
   logic                flag_hit, abort_hit, stuff_hit;
   logic [7:0]          byte_full;
   logic                special;
   logic [1:0]          push_n;
   hbd_pkg::result_type res0, res1;

   // Handshake: take a bit only when the queue is empty after this cycle's pop
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign req_stall = !((count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_xfer));
   assign req_xfer  = req_valid && !req_stall;

   assign rsp_out_byte = entry0_ff.data;
   assign rsp_last     = entry0_ff.last;

   // Configuration writes
   always_comb begin
      flag_in   = flag_ff;
      abort_in  = abort_ff;
      escape_in = escape_ff;
      if (csr_wr_en) begin
         unique case (hbd_pkg::csr_index_type'(csr_index))
            hbd_pkg::CSR_FLAG_PATTERN:  flag_in   = csr_wdata;
            hbd_pkg::CSR_ABORT_MASK:    abort_in  = csr_wdata;
            hbd_pkg::CSR_ESCAPE_MARKER: escape_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Pattern matching on the updated history
   assign history_in = req_xfer ? {history_ff[6:0], req_rx_bit} : history_ff;
   assign flag_hit   = (history_in == flag_ff);
   assign abort_hit  = ((history_in & abort_ff) == abort_ff);
   assign stuff_hit  = ((history_in & hbd_pkg::STUFF_MASK) == hbd_pkg::STUFF_MATCH);
   assign byte_full  = asm_ff | (req_rx_bit ? hbd_pkg::ENTRY_BIT : 8'h00);
   assign special    = (byte_full == flag_ff) || (byte_full == abort_ff) ||
                       (byte_full == escape_ff);

   // Per-bit decision
   always_comb begin
      in_frame_in = in_frame_ff;
      asm_in      = asm_ff;
      bit_cnt_in  = bit_cnt_ff;
      push_n      = 2'd0;
      res0        = '{data: flag_ff, last: 1'b1};
      res1        = '{data: byte_full, last: 1'b1};
      if (req_xfer) begin
         if (flag_hit) begin
            push_n      = 2'd1;
            in_frame_in = 1'b1;
            asm_in      = 8'h00;
            bit_cnt_in  = 3'd0;
         end else if (abort_hit) begin
            in_frame_in = 1'b0;
         end else if (in_frame_ff && !stuff_hit) begin
            if (bit_cnt_ff == 3'd7) begin
               asm_in     = 8'h00;
               bit_cnt_in = 3'd0;
               if (special) begin
                  push_n = 2'd2;
                  res0   = '{data: escape_ff, last: 1'b0};
               end else begin
                  push_n = 2'd1;
                  res0   = '{data: byte_full, last: 1'b1};
               end
            end else begin
               bit_cnt_in = bit_cnt_ff + 3'd1;
               asm_in     = byte_full >> 1;
            end
         end
      end
   end

   // Queue update: a transfer in always lands in an empty queue
   always_comb begin
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      count_in  = count_ff;
      if (req_xfer) begin
         entry0_in = res0;
         entry1_in = res1;
         count_in  = push_n;
      end else if (rsp_xfer) begin
         entry0_in = entry1_ff;
         count_in  = count_ff - 2'd1;
      end
   end

   // Control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff     <= hbd_pkg::FLAG_PATTERN_RST;
         abort_ff    <= hbd_pkg::ABORT_MASK_RST;
         escape_ff   <= hbd_pkg::ESCAPE_MARKER_RST;
         history_ff  <= 8'h00;
         in_frame_ff <= 1'b0;
         asm_ff      <= 8'h00;
         bit_cnt_ff  <= 3'd0;
         count_ff    <= 2'd0;
      end else begin
         flag_ff     <= flag_in;
         abort_ff    <= abort_in;
         escape_ff   <= escape_in;
         history_ff  <= history_in;
         in_frame_ff <= in_frame_in;
         asm_ff      <= asm_in;
         bit_cnt_ff  <= bit_cnt_in;
         count_ff    <= count_in;
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   // Checks
   `HBD_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)
   `HBD_ASSERT_IMPL(a_xfer_room, clock, reset, req_xfer,
                    (count_ff == 2'd0) || rsp_xfer)
   `HBD_ASSERT_IMPL(a_escape_pair, clock, reset, rsp_valid && !rsp_last,
                    (count_ff == 2'd2) && entry1_ff.last)
   `HBD_ASSERT_NEXT(a_flag_enters, clock, reset, req_xfer && flag_hit,
                    in_frame_ff && (bit_cnt_ff == 3'd0) && rsp_valid)

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for hdlc_bit_deframer: line bits in, deframed bytes out.
// Depends on hbd_pkg and the RTL top; predicts every result and compares in order.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 120;
   localparam int SETTLE_TICKS = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_rx_bit = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = hbd_pkg::CSR_FLAG_PATTERN;
   logic [7:0] csr_wdata = 8'h00;

   // Stimulus and scoreboard storage
   logic                pending_bits[$];
   hbd_pkg::result_type expected_bytes[$];
   int         queued_count = 0;
   int         fail_count = 0;
   int         cycle_count = 0;
   int         tx_idle_pct = 19;
   int         rx_idle_pct = 78;
   logic       hold_request = 1'b0;
   logic       hold_done = 1'b0;
   int         hold_left = 0;

   // Shadow registers and deframer state for prediction
   logic [7:0] cfg_flag   = hbd_pkg::FLAG_PATTERN_RST;
   logic [7:0] cfg_abort  = hbd_pkg::ABORT_MASK_RST;
   logic [7:0] cfg_escape = hbd_pkg::ESCAPE_MARKER_RST;
   logic [7:0] line_history = 8'h00;
   logic       framing = 1'b0;
   logic [7:0] partial_byte = 8'h00;
   logic [2:0] partial_count = 3'd0;

   hdlc_bit_deframer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_bit   (req_rx_bit),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Expected results for one transferred line bit
   function automatic void deframe_bit(input logic b);
      hbd_pkg::result_type r;
      line_history = {line_history[6:0], b};
      if (line_history == cfg_flag) begin
         r.data = cfg_flag;
         r.last = 1'b1;
         expected_bytes.push_back(r);
         framing = 1'b1;
         partial_byte = 8'h00;
         partial_count = 3'd0;
      end else if ((line_history & cfg_abort) == cfg_abort) begin
         framing = 1'b0;
      end else if (framing &&
                   ((line_history & hbd_pkg::STUFF_MASK) != hbd_pkg::STUFF_MATCH)) begin
         if (b) partial_byte = partial_byte | hbd_pkg::ENTRY_BIT;
         if (partial_count == 3'd7) begin
            if (partial_byte == cfg_flag || partial_byte == cfg_abort ||
                partial_byte == cfg_escape) begin
               r.data = cfg_escape;
               r.last = 1'b0;
               expected_bytes.push_back(r);
            end
            r.data = partial_byte;
            r.last = 1'b1;
            expected_bytes.push_back(r);
            partial_byte = 8'h00;
            partial_count = 3'd0;
         end else begin
            partial_count = partial_count + 3'd1;
            partial_byte = partial_byte >> 1;
         end
      end
   endfunction

   function automatic void push_bit(input logic b);
      pending_bits.push_back(b);
      queued_count++;
   endfunction

   // Flag goes out MSB first so it lines up in the history register
   function automatic void push_flag();
      for (int i = 7; i >= 0; i--) push_bit(cfg_flag[i]);
   endfunction

   // Data byte LSB first with a zero stuffed after five ones
   function automatic void push_data_byte(input logic [7:0] v, inout int ones);
      for (int i = 0; i < 8; i++) begin
         push_bit(v[i]);
         ones = v[i] ? ones + 1 : 0;
         if (ones == 5) begin
            push_bit(1'b0);
            ones = 0;
         end
      end
   endfunction

   // Mostly well-formed frames, some aborted or broken frames and line noise
   function automatic void make_traffic(input int count);
      int target;
      int ones;
      int pick;
      logic [7:0] v;
      target = queued_count + count;
      while (queued_count < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            push_flag();
            ones = 0;
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 7))
                  0: v = cfg_flag;
                  1: v = cfg_abort;
                  2: v = cfg_escape;
                  3: v = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                  default: v = 8'($urandom_range(0, 255));
               endcase
               push_data_byte(v, ones);
            end
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(7, 9)) push_bit(1'b1);
            end else begin
               push_flag();
            end
         end else if (pick < 9) begin
            push_flag();
            repeat ($urandom_range(4, 20)) push_bit(1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 12)) push_bit(1'($urandom_range(0, 1)));
         end
      end
   endfunction

   task automatic write_regs(input logic [7:0] f, input logic [7:0] a, input logic [7:0] e);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= hbd_pkg::CSR_FLAG_PATTERN;
      csr_wdata <= f;
      @(posedge clock);
      csr_index <= hbd_pkg::CSR_ABORT_MASK;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= hbd_pkg::CSR_ESCAPE_MARKER;
      csr_wdata <= e;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_flag = f;
      cfg_abort = a;
      cfg_escape = e;
   endtask

   // Wait until every bit is in and every result is out, then let the pipe drain
   task automatic settle();
      while (pending_bits.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Input side driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) deframe_bit(req_rx_bit);
         if (!(req_valid && req_stall)) begin
            if (pending_bits.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               req_valid <= 1'b1;
               req_rx_bit <= pending_bits.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side monitor and stall generator
   always @(posedge clock) begin : byte_monitor
      hbd_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: byte %h last %b", rsp_out_byte, rsp_last);
         end else begin
            want = expected_bytes.pop_front();
            if (want.data !== rsp_out_byte || want.last !== rsp_last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected byte %h last %b, got byte %h last %b",
                           want.data, want.last, rsp_out_byte, rsp_last);
            end
         end
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
   end

   // Long receiver hold-off, counted here once requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      // Directed: opening flag, a flag-valued byte with a stuffed zero, then an abort
      push_flag();
      push_bit(1'b0);
      repeat (5) push_bit(1'b1);
      push_bit(1'b0);
      push_bit(1'b1);
      push_bit(1'b0);
      repeat (7) push_bit(1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      make_traffic(PHASE_ITEMS);
      settle();

      for (int s = 1; s <= 5; s++) begin
         case (s)
            1: write_regs(8'h7E, 8'hFF, 8'h00);
            2: write_regs(8'hFF, 8'h00, 8'hFF);
            3: write_regs(8'h00, 8'h7F, 8'h7E);
            4: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            default: write_regs(hbd_pkg::FLAG_PATTERN_RST, hbd_pkg::ABORT_MASK_RST,
                                hbd_pkg::ESCAPE_MARKER_RST);
         endcase
         // Idle mix: receiver-heavy, then sender-heavy, then none
         if (s == 2) begin
            tx_idle_pct <= 78;
            rx_idle_pct <= 19;
         end else if (s == 4) begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
         end
         make_traffic(PHASE_ITEMS);
         if (s == 4) begin
            @(posedge clock);
            hold_request <= 1'b1;
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/hbd_pkg.sv
rtl/hdlc_bit_deframer.sv
verif/tb_top.sv
